[rtl/kth_smallest_in_range_union_unit_assert.svh]
// assertion macros used by the top rtl file
`ifndef KTH_SMALLEST_IN_RANGE_UNION_UNIT_ASSERT_SVH
`define KTH_SMALLEST_IN_RANGE_UNION_UNIT_ASSERT_SVH

// plain invariant, checked at every rising clock edge out of reset
`define KIRU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define KIRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KIRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/kiru_pkg.sv]
package kiru_pkg;

  localparam int unsigned MAX_RANGES_DEF = 64;
  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam int unsigned K_BITS         = 32;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // control from the sequencer to the merge unit
  typedef struct packed {
    logic start;
    logic ent;
    logic first;
    logic last;
  } mrg_ctl_t;

  // status back from the merge unit
  typedef struct packed {
    logic done;
    logic found;
  } mrg_st_t;

endpackage

[rtl/kth_smallest_in_range_union_unit.sv]
// Rank select over a union of closed integer ranges.
// Input channel (in_valid_i / in_ready_o) carries one transaction per item:
// kind_i 0 loads [range_start_i, range_end_i] (ends swapped if reversed),
// 1 queries rank rank_k_i, 2 clears the table, 3 is ignored.
// Output channel (out_valid_o / out_ready_i) returns found_o, value_o and
// table_full_o: one transaction per query, one per load dropped on a full
// table, none for an accepted load or a clear.
// Ranges sit sorted in one registered-read RAM; one item is worked at a time.
// A load keeps the block busy for its insertion walk over the N stored ranges
// (one entry moved per cycle), a query for its merge pass (one entry read and
// merged per cycle) with its result at the end; the next item is taken once
// the block is idle again. A full-table load, rank zero or an empty table
// answers without a walk or merge pass.
// Reset empties the table and drops any pending result; no clearing pass.
// A result waits in the output register while the receiver stalls; the
// block then holds its next result and accepts no new item until it drains.
`include "kth_smallest_in_range_union_unit_assert.svh"

module kth_smallest_in_range_union_unit #(
  parameter int unsigned MAX_RANGES = kiru_pkg::MAX_RANGES_DEF,
  parameter int unsigned VALUE_BITS = kiru_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [VALUE_BITS-1:0]       range_start_i,
  input  logic [VALUE_BITS-1:0]       range_end_i,
  input  logic [kiru_pkg::K_BITS-1:0] rank_k_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [VALUE_BITS-1:0]       value_o,
  output logic                        table_full_o
);
  import kiru_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned EW = 2 * VALUE_BITS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LD_RD  = 6'b000010,
    S_LD_CMP = 6'b000100,
    S_LD_WR  = 6'b001000,
    S_Q_RUN  = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic                  dv_q, dv_d, fv_q, fv_d;
  logic                  out_valid_q, out_valid_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [VALUE_BITS-1:0] ns_q, ns_d, ne_q, ne_d;
  logic                  res_found_q, res_found_d, res_full_q, res_full_d;
  logic [VALUE_BITS-1:0] res_value_q, res_value_d;
  logic                  found_q, found_d, full_q, full_d;
  logic [VALUE_BITS-1:0] value_q, value_d;

  logic                  acc;
  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [EW-1:0]         wr_data, rd_data;
  mrg_ctl_t              mctl;
  mrg_st_t               mst;
  logic [VALUE_BITS-1:0] m_value;

  function automatic logic sorts_after(input logic [VALUE_BITS-1:0] s1,
                                       input logic [VALUE_BITS-1:0] e1,
                                       input logic [VALUE_BITS-1:0] s2,
                                       input logic [VALUE_BITS-1:0] e2);
    logic r;
    if (s1 != s2) begin
      r = (s1 > s2);
    end else begin
      r = (e1 > e2);
    end
    return r;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    dv_d        = 1'b0;
    fv_d        = 1'b0;
    idx_d       = idx_q;
    ns_d        = ns_q;
    ne_d        = ne_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    res_value_d = res_value_q;
    found_d     = found_q;
    full_d      = full_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = {ne_q, ns_q};
    mctl        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (kind_i == KIND_LOAD) begin
            if (range_end_i < range_start_i) begin
              ns_d = range_end_i;
              ne_d = range_start_i;
            end else begin
              ns_d = range_start_i;
              ne_d = range_end_i;
            end
            if (count_q == CW'(MAX_RANGES)) begin
              res_found_d = 1'b0;
              res_value_d = '0;
              res_full_d  = 1'b1;
              state_d     = S_OUT;
            end else if (count_q == '0) begin
              idx_d   = '0;
              state_d = S_LD_WR;
            end else begin
              idx_d   = count_q[AW-1:0];
              state_d = S_LD_RD;
            end
          end else if (kind_i == KIND_QUERY) begin
            res_found_d = 1'b0;
            res_value_d = '0;
            res_full_d  = 1'b0;
            if (rank_k_i == '0 || count_q == '0) begin
              state_d = S_OUT;
            end else begin
              mctl.start = 1'b1;
              ptr_d      = '0;
              state_d    = S_Q_RUN;
            end
          end else if (kind_i == KIND_CLEAR) begin
            count_d = '0;
          end
        end
      end
      S_LD_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_q - AW'(1);
        state_d = S_LD_CMP;
      end
      S_LD_CMP: begin
        wr_en = 1'b1;
        if (sorts_after(rd_data[VALUE_BITS-1:0], rd_data[EW-1:VALUE_BITS], ns_q, ne_q)) begin
          wr_data = rd_data;
          idx_d   = idx_q - AW'(1);
          if (idx_q == AW'(1)) begin
            state_d = S_LD_WR;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q - AW'(2);
          end
        end else begin
          count_d = count_q + CW'(1);
          state_d = S_IDLE;
        end
      end
      S_LD_WR: begin
        wr_en   = 1'b1;
        count_d = count_q + CW'(1);
        state_d = S_IDLE;
      end
      S_Q_RUN: begin
        rd_en      = (ptr_q < count_q);
        rd_addr    = ptr_q[AW-1:0];
        dv_d       = rd_en;
        fv_d       = rd_en && (ptr_q == '0);
        mctl.ent   = dv_q;
        mctl.first = fv_q;
        mctl.last  = !dv_q && (ptr_q == count_q);
        if (rd_en) begin
          ptr_d = ptr_q + CW'(1);
        end
        if (mst.done) begin
          res_found_d = mst.found;
          res_value_d = mst.found ? m_value : '0;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          value_d     = res_value_q;
          full_d      = res_full_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      dv_q        <= 1'b0;
      fv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      dv_q        <= dv_d;
      fv_q        <= fv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    ns_q        <= ns_d;
    ne_q        <= ne_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    res_value_q <= res_value_d;
    found_q     <= found_d;
    full_q      <= full_d;
    value_q     <= value_d;
  end

  kiru_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_RANGES)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  kiru_merge #(
    .VALUE_BITS(VALUE_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .ctl_i      (mctl),
    .rank_k_i   (rank_k_i),
    .ent_start_i(rd_data[VALUE_BITS-1:0]),
    .ent_end_i  (rd_data[EW-1:VALUE_BITS]),
    .st_o       (mst),
    .value_o    (m_value)
  );

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign value_o      = value_q;
  assign table_full_o = full_q;

  `KIRU_ASSERT(a_count_bound, count_q <= CW'(MAX_RANGES), "range count beyond table depth")
  `KIRU_ASSERT_IMP(a_no_wr_in_query, state_q == S_Q_RUN, !wr_en, "table written during a query")
  `KIRU_ASSERT_IMP(a_rw_apart, wr_en && rd_en, wr_addr != rd_addr, "read and write hit one entry")
  `KIRU_ASSERT_NXT(a_ld_wr_count, state_q == S_LD_WR,
                   count_q == CW'($past(count_q) + CW'(1)), "final load write missed count")
  `KIRU_ASSERT_IMP(a_result_from_out, $rose(out_valid_q), $past(state_q == S_OUT),
                   "result raised outside the output state")

endmodule

[rtl/kiru_ram.sv]
module kiru_ram #(
  parameter int unsigned WIDTH = 62,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/kiru_merge.sv]
module kiru_merge #(
  parameter int unsigned VALUE_BITS = kiru_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  kiru_pkg::mrg_ctl_t            ctl_i,
  input  logic [kiru_pkg::K_BITS-1:0]   rank_k_i,
  input  logic [VALUE_BITS-1:0]         ent_start_i,
  input  logic [VALUE_BITS-1:0]         ent_end_i,
  output kiru_pkg::mrg_st_t             st_o,
  output logic [VALUE_BITS-1:0]         value_o
);
  import kiru_pkg::*;

  localparam int unsigned LW = VALUE_BITS + 1;
  localparam int unsigned CW = (K_BITS > LW) ? K_BITS : LW;

  logic [VALUE_BITS-1:0] cs_q, ce_q;
  logic [K_BITS-1:0]     k_q;
  logic [LW-1:0]         len;
  logic [CW-1:0]         kx, lx;
  logic                  hit, joins, close;

  always_comb begin
    len   = {1'b0, ce_q} - {1'b0, cs_q} + LW'(1);
    kx    = CW'(k_q);
    lx    = CW'(len);
    hit   = (kx <= lx);
    joins = ({1'b0, ent_start_i} <= ({1'b0, ce_q} + LW'(1)));
    close = (ctl_i.ent && !ctl_i.first && !joins) || ctl_i.last;
    st_o.done  = close && (hit || ctl_i.last);
    st_o.found = close && hit;
    value_o    = VALUE_BITS'(CW'(cs_q) + kx - CW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      k_q <= rank_k_i;
    end else if (close && !hit) begin
      k_q <= K_BITS'(kx - lx);
    end
    if (ctl_i.ent) begin
      if (ctl_i.first || !joins) begin
        cs_q <= ent_start_i;
        ce_q <= ent_end_i;
      end else if (ent_end_i > ce_q) begin
        ce_q <= ent_end_i;
      end
    end
  end

endmodule

[sim/tb_kth_smallest_in_range_union_unit.sv]
`timescale 1ns / 1ps

module tb_kth_smallest_in_range_union_unit;
  import kiru_pkg::*;

  localparam int unsigned VB = VALUE_BITS_DEF;
  localparam int unsigned MAXR = MAX_RANGES_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [VB-1:0] TOP_VAL = {VB{1'b1}};

  typedef struct {
    logic [1:0]        kind;
    logic [VB-1:0]     lo;
    logic [VB-1:0]     hi;
    logic [K_BITS-1:0] rank;
    bit                drain;
  } union_req_t;

  typedef struct {
    logic          found;
    logic [VB-1:0] value;
    logic          full;
  } rank_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              found;
  logic [VB-1:0]     value;
  logic              table_full;
  union_req_t        cur_req = '{KIND_LOAD, '0, '0, '0, 1'b0};

  union_req_t        req_queue[$];
  rank_result_t      rank_answers[$];

  logic [VB-1:0]     start_tab[MAXR];
  logic [VB-1:0]     end_tab[MAXR];
  int                stored_cnt = 0;

  bit                in_taken = 1'b0;
  bit                calm = 1'b0;
  bit                hold_done = 1'b0;
  int                send_gap = 0;
  int                recv_gap = 0;
  int                hold_left = 0;
  int                errors = 0;
  int                results_seen = 0;
  int                items_made = 0;
  int                n_loads = 0;
  int                n_clears = 0;
  int                n_found = 0;
  int                n_missed = 0;
  int                n_dropped = 0;
  longint unsigned   span_sum = 0;
  logic [VB-1:0]     chain_end = '0;

  kth_smallest_in_range_union_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (cur_req.kind),
    .range_start_i(cur_req.lo),
    .range_end_i  (cur_req.hi),
    .rank_k_i     (cur_req.rank),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .found_o      (found),
    .value_o      (value),
    .table_full_o (table_full)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #20000000;
    $display("%0t: timeout", $time);
    $display("tb_kth_smallest_in_range_union_unit: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 999);
    if (r < 8) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // expected outcome of one accepted transaction
  task automatic union_model_step(input union_req_t r);
    logic [VB-1:0]   s;
    logic [VB-1:0]   e;
    logic [VB-1:0]   t;
    int              pos;
    longint unsigned cs;
    longint unsigned ce;
    longint unsigned len;
    longint unsigned kk;
    longint unsigned pick;
    bit              hit;
    rank_result_t    res;
    s = r.lo;
    e = r.hi;
    res = '{1'b0, '0, 1'b0};
    case (r.kind)
      KIND_LOAD: begin
        n_loads++;
        if (e < s) begin
          t = s;
          s = e;
          e = t;
        end
        if (stored_cnt >= MAXR) begin
          res.full = 1'b1;
          rank_answers.insert(rank_answers.size(), res);
        end else begin
          pos = stored_cnt;
          while (pos > 0 && (start_tab[pos-1] > s ||
                 (start_tab[pos-1] == s && end_tab[pos-1] > e)))
            pos--;
          for (int i = stored_cnt; i > pos; i--) begin
            start_tab[i] = start_tab[i-1];
            end_tab[i] = end_tab[i-1];
          end
          start_tab[pos] = s;
          end_tab[pos] = e;
          stored_cnt++;
        end
      end
      KIND_QUERY: begin
        kk = 64'(r.rank);
        hit = 1'b0;
        if (kk != 0 && stored_cnt != 0) begin
          cs = 64'(start_tab[0]);
          ce = 64'(end_tab[0]);
          for (int i = 1; i <= stored_cnt && !hit; i++) begin
            if (i < stored_cnt && 64'(start_tab[i]) <= ce + 64'd1) begin
              if (64'(end_tab[i]) > ce) ce = 64'(end_tab[i]);
            end else begin
              len = ce - cs + 64'd1;
              if (kk <= len) begin
                hit = 1'b1;
                pick = cs + kk - 64'd1;
                res.value = pick[VB-1:0];
              end else begin
                kk -= len;
                if (i < stored_cnt) begin
                  cs = 64'(start_tab[i]);
                  ce = 64'(end_tab[i]);
                end
              end
            end
          end
        end
        res.found = hit;
        rank_answers.insert(rank_answers.size(), res);
      end
      KIND_CLEAR: begin
        n_clears++;
        stored_cnt = 0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_item(input logic [1:0] kind, input logic [VB-1:0] s,
                           input logic [VB-1:0] e, input logic [K_BITS-1:0] k);
    union_req_t r;
    r = '{kind, s, e, k, 1'b0};
    req_queue.insert(req_queue.size(), r);
    if (kind != KIND_UNUSED) items_made++;
    if (kind == KIND_LOAD) span_sum += 64'((e > s) ? e - s : s - e) + 64'd1;
    if (kind == KIND_CLEAR) span_sum = 0;
  endtask

  task automatic push_pause();
    union_req_t r;
    r = '{KIND_UNUSED, '0, '0, '0, 1'b1};
    req_queue.insert(req_queue.size(), r);
  endtask

  // output side checks first so a same-edge input cannot satisfy it
  always @(posedge clk_i) begin
    rank_result_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (table_full) n_dropped++;
        else if (found) n_found++;
        else n_missed++;
        if (rank_answers.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, got found=%0b value=%0h full=%0b",
                   $time, found, value, table_full);
          errors++;
        end else begin
          want = rank_answers.pop_front();
          if (found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, got %0b", $time, want.found, found);
            errors++;
          end
          if (value !== want.value) begin
            $display("%0t: value mismatch: expected %0h, got %0h", $time, want.value, value);
            errors++;
          end
          if (table_full !== want.full) begin
            $display("%0t: table_full mismatch: expected %0b, got %0b",
                     $time, want.full, table_full);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        union_model_step(cur_req);
      end
    end
  end

  always @(negedge clk_i) begin
    union_req_t nxt;
    logic       offer;
    nxt = cur_req;
    offer = in_valid;
    if (in_taken) begin
      offer = 1'b0;
      in_taken = 1'b0;
    end
    if (rst_ni && !offer) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (req_queue.size() > 0) begin
        if (req_queue[0].drain) begin
          if (rank_answers.size() == 0) req_queue.delete(0);
        end else begin
          nxt = req_queue.pop_front();
          offer = 1'b1;
          send_gap = pick_gap();
        end
      end
    end
    in_valid <= offer;
    cur_req <= nxt;
  end

  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      // one long back-pressure stretch so the block fills and stalls its input
      if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else begin
        rdy = 1'b1;
        recv_gap = pick_gap();
      end
    end
    out_ready <= rdy;
  end

  initial begin
    logic [VB-1:0]     s;
    logic [VB-1:0]     e;
    logic [VB-1:0]     t;
    logic [K_BITS-1:0] k;
    longint unsigned   cap;
    int                r;
    int                mode;
    int                nloads;
    int                nq;

    push_item(KIND_QUERY, '0, '0, 32'd1);
    push_item(KIND_UNUSED, 31'd3, 31'd9, 32'd1);
    push_item(KIND_LOAD, 31'd10, 31'd5, '0);
    push_item(KIND_LOAD, 31'd11, 31'd11, '0);
    push_item(KIND_LOAD, 31'd0, 31'd0, '0);
    push_item(KIND_LOAD, TOP_VAL, TOP_VAL - 31'd3, '0);
    push_item(KIND_LOAD, 31'd20, 31'd30, '0);
    push_item(KIND_LOAD, 31'd25, 31'd28, '0);
    push_item(KIND_LOAD, 31'd20, 31'd30, '0);
    push_item(KIND_QUERY, '0, '0, 32'd0);
    push_item(KIND_QUERY, '0, '0, 32'd1);
    push_item(KIND_QUERY, '0, '0, 32'd2);
    push_item(KIND_QUERY, '0, '0, 32'd8);
    push_item(KIND_QUERY, '0, '0, 32'd9);
    push_item(KIND_QUERY, '0, '0, 32'd19);
    push_item(KIND_QUERY, '0, '0, 32'd20);
    push_item(KIND_QUERY, '0, '0, 32'd23);
    push_item(KIND_QUERY, '0, '0, 32'd24);
    push_item(KIND_QUERY, TOP_VAL, TOP_VAL, 32'hFFFF_FFFF);
    push_item(KIND_CLEAR, '0, '0, '0);
    push_item(KIND_QUERY, '0, '0, 32'd1);
    push_item(KIND_LOAD, 31'd0, TOP_VAL, '0);
    push_item(KIND_QUERY, '0, '0, 32'h8000_0000);
    push_item(KIND_QUERY, '0, '0, 32'h8000_0001);
    push_item(KIND_CLEAR, '0, '0, '0);
    push_pause();

    while (items_made < 1850) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if ($urandom_range(0, 4) != 0) begin
          push_item(KIND_CLEAR, VB'($urandom), VB'($urandom), $urandom);
        end
        mode = $urandom_range(0, 3);
        nloads = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
        for (int i = 0; i < nloads; i++) begin
          case (mode)
            0: begin
              s = VB'($urandom_range(0, 400));
              e = s + VB'($urandom_range(0, 25));
            end
            1: begin
              s = VB'($urandom);
              e = VB'($urandom);
            end
            2: begin
              s = TOP_VAL - VB'($urandom_range(0, 300));
              t = VB'($urandom_range(0, 20));
              e = (TOP_VAL - s < t) ? TOP_VAL : s + t;
            end
            default: begin
              // chains of touching or overlapping ranges
              s = chain_end + VB'($urandom_range(0, 2)) - VB'(1);
              e = s + VB'($urandom_range(0, 10));
              chain_end = e;
            end
          endcase
          if ($urandom_range(0, 4) == 0) begin
            t = s;
            s = e;
            e = t;
          end
          push_item(KIND_LOAD, s, e, $urandom);
        end
        nq = $urandom_range(2, 8);
        for (int i = 0; i < nq; i++) begin
          cap = (span_sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : span_sum;
          r = $urandom_range(0, 99);
          if (r < 8 || cap == 0) k = $urandom_range(0, 3);
          else if (r < 16) k = $urandom;
          else if (r < 26) k = K_BITS'(cap + 64'($urandom_range(0, 2)));
          else if (r < 60) k = $urandom_range(1, 32'((cap > 64) ? 64 : cap));
          else k = $urandom_range(1, 32'(cap));
          push_item(KIND_QUERY, VB'($urandom), VB'($urandom), k);
        end
      end else if (r < 97) begin
        push_item(2'($urandom_range(0, 3)), VB'($urandom), VB'($urandom), $urandom);
      end else begin
        push_pause();
      end
    end

    while (req_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (rank_answers.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("run covered %0d loads (%0d dropped on a full table), %0d clears, %0d queries",
             n_loads, n_dropped, n_clears, n_found + n_missed);
    $display("queries answered: %0d found, %0d not found; %0d check errors",
             n_found, n_missed, errors);
    if (errors == 0) begin
      $display("tb_kth_smallest_in_range_union_unit: PASS");
    end else begin
      $display("tb_kth_smallest_in_range_union_unit: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/kiru_pkg.sv
rtl/kiru_ram.sv
rtl/kiru_merge.sv
rtl/kth_smallest_in_range_union_unit.sv
sim/tb_kth_smallest_in_range_union_unit.sv
